/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sfk_pkg.sv */
// ----------------------------------------------------------------------------
// sfk_pkg
// types, constants and microcode for the square-free kernel split unit
// ----------------------------------------------------------------------------
package sfk_pkg;

  localparam int VALUE_BITS_DEF = 20;
  localparam int KERNEL_W       = 20;
  localparam int LOW_W          = 10;
  localparam int STEP_W         = 4;
  localparam int FIRST_DIVISOR  = 2;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_TEST,
    OP_DIV_SQ,
    OP_APPLY_SQ,
    OP_INIT_I,
    OP_DIV_I,
    OP_STEP_I,
    OP_EMIT_FOUND,
    OP_EMIT_PLAIN
  } op_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_JUMP,
    COND_SQ_GT_X,
    COND_REM_NZ
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic hold;
    logic sq_gt_x;
    logic rem_nz;
  } status_t;

  localparam step_t ST_ACCEPT      = 4'd0;
  localparam step_t ST_TEST_SQ     = 4'd1;
  localparam step_t ST_DIV_SQ      = 4'd2;
  localparam step_t ST_APPLY_SQ    = 4'd3;
  localparam step_t ST_INIT_I      = 4'd4;
  localparam step_t ST_TEST_I      = 4'd5;
  localparam step_t ST_DIV_I       = 4'd6;
  localparam step_t ST_STEP_I      = 4'd7;
  localparam step_t ST_EMIT_FOUND  = 4'd8;
  localparam step_t ST_EMIT_PLAIN  = 4'd9;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    case (s)
      ST_ACCEPT:     w = '{op: OP_ACCEPT,     cond: COND_NEXT,    target: ST_ACCEPT};
      ST_TEST_SQ:    w = '{op: OP_TEST,       cond: COND_SQ_GT_X, target: ST_INIT_I};
      ST_DIV_SQ:     w = '{op: OP_DIV_SQ,     cond: COND_NEXT,    target: ST_ACCEPT};
      ST_APPLY_SQ:   w = '{op: OP_APPLY_SQ,   cond: COND_JUMP,    target: ST_TEST_SQ};
      ST_INIT_I:     w = '{op: OP_INIT_I,     cond: COND_NEXT,    target: ST_ACCEPT};
      ST_TEST_I:     w = '{op: OP_TEST,       cond: COND_SQ_GT_X, target: ST_EMIT_PLAIN};
      ST_DIV_I:      w = '{op: OP_DIV_I,      cond: COND_NEXT,    target: ST_ACCEPT};
      ST_STEP_I:     w = '{op: OP_STEP_I,     cond: COND_REM_NZ,  target: ST_TEST_I};
      ST_EMIT_FOUND: w = '{op: OP_EMIT_FOUND, cond: COND_JUMP,    target: ST_ACCEPT};
      ST_EMIT_PLAIN: w = '{op: OP_EMIT_PLAIN, cond: COND_JUMP,    target: ST_ACCEPT};
      default:       w = '{op: OP_NOP,        cond: COND_JUMP,    target: ST_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/sfk_if.sv */
// ----------------------------------------------------------------------------
// sfk_in_if / sfk_out_if
// valid/ready channels for operand items and result items
// ----------------------------------------------------------------------------
interface sfk_in_if #(
  parameter int VALUE_BITS = sfk_pkg::VALUE_BITS_DEF
);
  import sfk_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sfk_out_if;
  import sfk_pkg::*;

  logic                valid;
  logic                ready;
  logic [KERNEL_W-1:0] kernel;
  logic [LOW_W-1:0]    low_factor;
  logic [KERNEL_W-1:0] high_factor;
  logic                was_square;

  modport source (output valid, output kernel, output low_factor, output high_factor,
                  output was_square, input ready);
  modport sink   (input valid, input kernel, input low_factor, input high_factor,
                  input was_square, output ready);
endinterface

/* hw/rtl/square_free_kernel_split_unit.sv */
// ----------------------------------------------------------------------------
// square_free_kernel_split_unit
// strips square factors from a value and splits the remaining kernel
//
// operand channel carries one value per item; result channel returns kernel,
// low_factor, high_factor and was_square for it, one result per item.
// a microcoded sequencer drives a datapath of running value, trial divisor i
// and its square, plus a shared one-bit-per-cycle divider.
// every trial divisor costs one divide plus two control steps, so an item's
// time grows with the trial divisors tried, up to sqrt(value) in each of the
// two passes; the worst case is a prime near the top of the range.
// the operand channel is ready only while the sequencer waits for an item;
// a finished result sits in an output register, so the next item is taken
// while the result still waits. when the receiver stalls and a new result
// is ready, the sequencer holds at its emit step.
// reset (synchronous) returns the sequencer to its wait step and drops the
// result valid; no memory needs clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module square_free_kernel_split_unit #(
  parameter int VALUE_BITS = sfk_pkg::VALUE_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  sfk_in_if.sink    operand,
  sfk_out_if.source result
);
  import sfk_pkg::*;

  localparam int IW  = VALUE_BITS / 2 + 2;
  localparam int SQW = VALUE_BITS + 1;

  ctrl_t   word;
  status_t status;

  logic [VALUE_BITS-1:0] x;
  logic [IW-1:0]         i;
  logic [SQW-1:0]        sq;

  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_divisor;
  logic [VALUE_BITS-1:0] div_quot;
  logic [VALUE_BITS-1:0] div_rem;

  logic out_valid;
  logic out_busy;
  logic is_div;
  logic in_fire;
  logic factor_ok;

  sfk_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .word   (word)
  );

  sfk_divider #(.W(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (x),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign is_div      = (word.op == OP_DIV_SQ) || (word.op == OP_DIV_I);
  assign div_start   = is_div && !div_busy && !div_done;
  assign div_divisor = (word.op == OP_DIV_SQ) ? VALUE_BITS'(sq) : VALUE_BITS'(i);
  assign out_busy    = out_valid && !result.ready;

  assign operand.ready = (word.op == OP_ACCEPT);
  assign result.valid  = out_valid;

  assign in_fire   = operand.valid && operand.ready;
  assign factor_ok = (VALUE_BITS > KERNEL_W) ||
                     ((32'(result.low_factor) * 32'(result.high_factor)) == 32'(result.kernel));

  always_comb begin
    status.sq_gt_x = sq > {1'b0, x};
    status.rem_nz  = div_rem != '0;
    case (word.op)
      OP_ACCEPT:     status.hold = !operand.valid;
      OP_DIV_SQ:     status.hold = !div_done;
      OP_DIV_I:      status.hold = !div_done;
      OP_EMIT_FOUND: status.hold = out_busy;
      OP_EMIT_PLAIN: status.hold = out_busy;
      default:       status.hold = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    case (word.op)
      OP_ACCEPT: begin
        if (operand.valid) begin
          x  <= operand.value;
          i  <= IW'(FIRST_DIVISOR);
          sq <= SQW'(FIRST_DIVISOR * FIRST_DIVISOR);
        end
      end
      OP_APPLY_SQ: begin
        if (div_rem == '0) begin
          x <= div_quot;
        end else begin
          i  <= i + 1'b1;
          sq <= sq + SQW'({i, 1'b1});
        end
      end
      OP_INIT_I: begin
        i  <= IW'(FIRST_DIVISOR);
        sq <= SQW'(FIRST_DIVISOR * FIRST_DIVISOR);
      end
      OP_STEP_I: begin
        if (div_rem != '0) begin
          i  <= i + 1'b1;
          sq <= sq + SQW'({i, 1'b1});
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((word.op == OP_EMIT_FOUND || word.op == OP_EMIT_PLAIN) && !out_busy) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_busy) begin
      if (word.op == OP_EMIT_FOUND) begin
        result.kernel      <= KERNEL_W'(x);
        result.low_factor  <= LOW_W'(i);
        result.high_factor <= KERNEL_W'(div_quot);
        result.was_square  <= (x == VALUE_BITS'(1));
      end else if (word.op == OP_EMIT_PLAIN) begin
        result.kernel      <= KERNEL_W'(x);
        result.low_factor  <= LOW_W'(1);
        result.high_factor <= KERNEL_W'(x);
        result.was_square  <= (x == VALUE_BITS'(1));
      end
    end
  end

  `ASSERT_NEXT(a_operand_load, clk, rst, in_fire, x == $past(operand.value), "operand not loaded")

  `ASSERT_IMPL(a_ready_div_idle, clk, rst, operand.ready, !div_busy, "divider busy at accept")

  `ASSERT_IMPL(a_factor_product, clk, rst, result.valid, factor_ok, "factors do not give kernel")

endmodule

/* hw/rtl/sfk_divider.sv */
// ----------------------------------------------------------------------------
// sfk_divider
// restoring divider, one quotient bit per cycle, results held until next start
// ----------------------------------------------------------------------------
module sfk_divider #(
  parameter int W = sfk_pkg::VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  import sfk_pkg::*;

  localparam int CW = $clog2(W);

  logic [CW-1:0] cnt;
  logic [W-1:0]  dsr;
  logic [W:0]    trial;
  logic          fits;

  assign trial = {rem, quot[W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
      cnt  <= CW'(W - 1);
    end else if (busy) begin
      rem  <= fits ? W'(trial - {1'b0, dsr}) : trial[W-1:0];
      quot <= {quot[W-2:0], fits};
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

/* hw/rtl/sfk_sequencer.sv */
// ----------------------------------------------------------------------------
// sfk_sequencer
// step counter over the microcode rom with hold and conditional jumps
// ----------------------------------------------------------------------------
module sfk_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  sfk_pkg::status_t status,
  output sfk_pkg::ctrl_t   word
);
  import sfk_pkg::*;

  step_t step;
  step_t step_next;
  logic  take;

  assign word = ucode(step);

  always_comb begin
    case (word.cond)
      COND_NEXT:    take = 1'b0;
      COND_JUMP:    take = 1'b1;
      COND_SQ_GT_X: take = status.sq_gt_x;
      COND_REM_NZ:  take = status.rem_nz;
      default:      take = 1'b1;
    endcase
    if (status.hold) begin
      step_next = step;
    end else if (take) begin
      step_next = word.target;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

endmodule
